[src/bpam_pkg.sv]
// Shared types, constants and codes of the bitmap page allocator and mapper.
`timescale 1ns / 1ps

package bpam_pkg;

    localparam int DEF_POOL_PAGES  = 16384;
    localparam int DEF_MAX_RUN     = 64;
    localparam int DEF_DIR_ENTRIES = 1024;

    localparam int WORD_BITS   = 8;
    localparam int WORD_SHIFT  = 3;
    localparam int PAGE_SHIFT  = 12;
    localparam int COUNT_LIMIT = 3840;
    localparam int KP_W        = 15;
    localparam int DIR_W       = 10;
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0]     RST_VIRT_BASE  = 32'hC010_0000;
    localparam logic [31:0]     RST_PHYS_START = 32'h0020_0000;
    localparam logic [KP_W-1:0] RST_KPAGES     = 15'd3840;
    localparam logic [DIR_W-1:0] RST_DIR_FIRST = 10'd768;
    localparam logic [DIR_W-1:0] RST_DIR_LAST  = 10'd1022;

    localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KPAGES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_LAST   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_COUNT = 3'd1,
        ST_USER_POOL = 3'd2,
        ST_NO_RUN    = 3'd3,
        ST_NO_FRAME  = 3'd4,
        ST_NO_TABLE  = 3'd5
    } status_t;

    typedef struct packed {
        logic        pool_select;
        logic [11:0] page_count;
    } in_t;

    typedef struct packed {
        logic [31:0] virt_addr;
        logic [31:0] frame_addr;
        logic        new_table;
        logic [31:0] table_addr;
        status_t     status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic       found;
        logic [2:0] pos;
        logic       free_found;
        logic [2:0] free_pos;
    } scan_t;

endpackage

[src/bpam_word_scan.sv]
// Scans one bitmap word: extends a free run and finds the lowest free bit.
`timescale 1ns / 1ps

module bpam_word_scan #(
    parameter int RW = 7
) (
    input  logic [bpam_pkg::WORD_BITS-1:0] word,
    input  logic [RW-1:0]                  run_in,
    input  logic [RW-1:0]                  cnt,
    output bpam_pkg::scan_t                res,
    output logic [RW-1:0]                  run_out
);
    import bpam_pkg::*;

    always_comb
    begin
        logic [RW-1:0] run;
        run = run_in;
        res = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (word[j])
            begin
                run = '0;
            end
            else
            begin
                run = run + 1'b1;
                if (!res.found && run == cnt)
                begin
                    res.found = 1'b1;
                    res.pos   = 3'(j);
                end
            end
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!word[j])
            begin
                res.free_found = 1'b1;
                res.free_pos   = 3'(j);
            end
        end
        run_out = run;
    end

endmodule

[src/bitmap_page_allocator_mapper_core.sv]
// Top level of the bitmap page allocator and two-level page mapper.
`timescale 1ns / 1ps

// How the block is used.
// A request on the input channel (in_valid, in_stall, in_data) asks for a run of
// page_count contiguous kernel pages. The block answers on the output channel
// (out_valid, out_stall, out_data) with one result per mapped page, the final one
// marked by last; an error ends the request with a single result carrying last.
// Registers are written on the cfg channel, which is always ready, while idle;
// the user is bound to this and the block itself does not enforce it. Requests
// are taken one at a time; in_stall is high while one is in work. The used
// bitmaps sit in memories of 8-bit words with a registered read, so every
// bitmap word visited takes a read state before it is used. A request searches
// the virtual bitmap for a run, marks each word of the run with a read and a
// write, and for every frame taken searches the frame bitmap anew from word zero.
// After reset a clearing pass over max(POOL_PAGES/8, DIR_ENTRIES) addresses
// zeroes all three memories; no request is taken during it.
// A stalled receiver holds the output register; the block then waits with the
// next result and carries on as soon as the register is taken.

module bitmap_page_allocator_mapper_core #(
    parameter int POOL_PAGES  = bpam_pkg::DEF_POOL_PAGES,
    parameter int MAX_RUN     = bpam_pkg::DEF_MAX_RUN,
    parameter int DIR_ENTRIES = bpam_pkg::DEF_DIR_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bpam_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bpam_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);
    import bpam_pkg::*;

    localparam int WORDS  = POOL_PAGES / WORD_BITS;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW     = $clog2(POOL_PAGES);
    localparam int RW     = $clog2(MAX_RUN + 1);
    localparam int DW     = $clog2(DIR_ENTRIES);
    localparam int CLR_N  = (WORDS > DIR_ENTRIES) ? WORDS : DIR_ENTRIES;
    localparam int CW     = $clog2(CLR_N);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_V_RD, S_V_CHK, S_M_RD, S_M_WR,
        S_PAGE, S_F_RD, S_F_CHK, S_POST
    } state_t;

    // Memories: used bitmaps in words, and the directory present bits.
    logic [WORD_BITS-1:0] virt_mem  [WORDS];
    logic [WORD_BITS-1:0] frame_mem [WORDS];
    logic                 dir_mem   [DIR_ENTRIES];

    state_t               state_reg, ret_reg;
    logic [CW-1:0]        clr_reg;
    logic [31:0]          virt_base_reg, phys_start_reg;
    logic [KP_W-1:0]      kpages_reg;
    logic [DIR_W-1:0]     dir_first_reg, dir_last_reg;
    logic [RW-1:0]        cnt_reg, run_reg, page_reg;
    logic [WAW-1:0]       word_reg;
    logic [PW-1:0]        start_reg;
    logic [31:0]          va_reg, frame_reg;
    logic                 tflag_reg;
    out_t                 res_reg, out_reg;
    logic                 out_valid_reg;

    logic [WORD_BITS-1:0] virt_q, frame_q;
    logic                 dir_q;

    logic                 virt_we, frame_we, dir_we;
    logic [WAW-1:0]       virt_wa, frame_wa;
    logic [WORD_BITS-1:0] virt_wd, frame_wd;
    logic [DW-1:0]        dir_wa;
    logic                 dir_wd;

    scan_t                sc;
    logic [RW-1:0]        run_out;
    logic [WORD_BITS-1:0] run_mask;
    logic [31:0]          len32;
    logic [WAW:0]         nwords;
    logic                 last_word;
    logic [WAW-1:0]       end_word;
    logic [PW-1:0]        start_calc;
    logic [31:0]          va_calc, faddr_calc;
    logic [DW-1:0]        dir_idx;
    logic                 dir_here;
    logic                 slot_free;
    logic                 bad_count;

    // An error ends a request with one result that carries only its status and last.
    function automatic out_t error_result(status_t st);
        out_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    bpam_word_scan #(.RW(RW)) u_scan (
        .word    ((state_reg == S_V_CHK) ? virt_q : frame_q),
        .run_in  (run_reg),
        .cnt     (cnt_reg),
        .res     (sc),
        .run_out (run_out)
    );

    // Bitmap length is the kernel page count saturated to the pool, in whole words.
    assign len32     = (32'(kpages_reg) > 32'(POOL_PAGES)) ? 32'(POOL_PAGES)
                                                           : 32'(kpages_reg);
    assign nwords    = (WAW + 1)'(len32 >> WORD_SHIFT);
    assign last_word = ((WAW + 1)'(word_reg) + 1'b1) == nwords;
    assign end_word  = WAW'((32'(start_reg) + 32'(cnt_reg) - 32'd1) >> WORD_SHIFT);
    assign start_calc = PW'((32'(word_reg) << WORD_SHIFT) + 32'(sc.pos) + 32'd1
                            - 32'(cnt_reg));
    assign va_calc    = virt_base_reg
                        + ((32'(start_reg) + 32'(page_reg)) << PAGE_SHIFT);
    assign faddr_calc = phys_start_reg
                        + (32'({word_reg, sc.free_pos}) << PAGE_SHIFT);
    assign dir_idx    = va_reg[31 -: DW];
    assign dir_here   = dir_q || (dir_first_reg <= dir_last_reg
                                  && DIR_W'(dir_idx) >= dir_first_reg
                                  && DIR_W'(dir_idx) <= dir_last_reg);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign bad_count  = in_data.page_count == 12'd0
                        || in_data.page_count > 12'(MAX_RUN)
                        || in_data.page_count >= 12'(COUNT_LIMIT);

    always_comb
    begin
        logic [31:0] g;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            g = (32'(word_reg) << WORD_SHIFT) + 32'(j);
            run_mask[j] = g >= 32'(start_reg) && g < 32'(start_reg) + 32'(cnt_reg);
        end
    end

    // Write ports of the three memories.
    always_comb
    begin
        virt_we  = 1'b0;
        virt_wa  = word_reg;
        virt_wd  = virt_q | run_mask;
        frame_we = 1'b0;
        frame_wa = word_reg;
        frame_wd = frame_q | (WORD_BITS'(1) << sc.free_pos);
        dir_we   = 1'b0;
        dir_wa   = dir_idx;
        dir_wd   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                virt_wa  = WAW'(clr_reg);
                virt_wd  = '0;
                frame_wa = WAW'(clr_reg);
                frame_wd = '0;
                dir_wa   = DW'(clr_reg);
                dir_wd   = 1'b0;
                virt_we  = 32'(clr_reg) < 32'(WORDS);
                frame_we = 32'(clr_reg) < 32'(WORDS);
                dir_we   = 32'(clr_reg) < 32'(DIR_ENTRIES);
            end
            S_M_WR:
            begin
                virt_we = 1'b1;
            end
            S_F_CHK:
            begin
                frame_we = sc.free_found;
                dir_we   = sc.free_found && tflag_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (virt_we)
        begin
            virt_mem[virt_wa] <= virt_wd;
        end
        virt_q <= virt_mem[word_reg];
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_wa] <= frame_wd;
        end
        frame_q <= frame_mem[word_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_wa] <= dir_wd;
        end
        if (state_reg == S_PAGE)
        begin
            dir_q <= dir_mem[va_calc[31 -: DW]];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virt_base_reg  <= RST_VIRT_BASE;
            phys_start_reg <= RST_PHYS_START;
            kpages_reg     <= RST_KPAGES;
            dir_first_reg  <= RST_DIR_FIRST;
            dir_last_reg   <= RST_DIR_LAST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VIRT_BASE:  virt_base_reg  <= cfg_data;
                CFG_PHYS_START: phys_start_reg <= cfg_data;
                CFG_KPAGES:     kpages_reg     <= cfg_data[KP_W-1:0];
                CFG_DIR_FIRST:  dir_first_reg  <= cfg_data[DIR_W-1:0];
                CFG_DIR_LAST:   dir_last_reg   <= cfg_data[DIR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            run_reg       <= '0;
            page_reg      <= '0;
            word_reg      <= '0;
            start_reg     <= '0;
            tflag_reg     <= 1'b0;
        end
        else
        begin
            // In S_POST the output register is refilled whenever it is free.
            if (out_valid_reg && !out_stall && state_reg != S_POST)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == 32'(CLR_N - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ret_reg   <= S_IDLE;
                        cnt_reg   <= RW'(in_data.page_count);
                        run_reg   <= '0;
                        word_reg  <= '0;
                        page_reg  <= '0;
                        tflag_reg <= 1'b0;
                        if (bad_count)
                        begin
                            res_reg   <= error_result(ST_BAD_COUNT);
                            state_reg <= S_POST;
                        end
                        else if (in_data.pool_select)
                        begin
                            res_reg   <= error_result(ST_USER_POOL);
                            state_reg <= S_POST;
                        end
                        else if (nwords == '0)
                        begin
                            res_reg   <= error_result(ST_NO_RUN);
                            state_reg <= S_POST;
                        end
                        else
                        begin
                            state_reg <= S_V_RD;
                        end
                    end
                end
                S_V_RD:
                begin
                    state_reg <= S_V_CHK;
                end
                S_V_CHK:
                begin
                    run_reg <= run_out;
                    if (sc.found)
                    begin
                        start_reg <= start_calc;
                        word_reg  <= WAW'(32'(start_calc) >> WORD_SHIFT);
                        state_reg <= S_M_RD;
                    end
                    else if (last_word)
                    begin
                        res_reg   <= error_result(ST_NO_RUN);
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_V_RD;
                    end
                end
                S_M_RD:
                begin
                    state_reg <= S_M_WR;
                end
                S_M_WR:
                begin
                    if (word_reg == end_word)
                    begin
                        state_reg <= S_PAGE;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_M_RD;
                    end
                end
                S_PAGE:
                begin
                    // The directory bit for this page is read here and lands in dir_q.
                    va_reg    <= va_calc;
                    word_reg  <= '0;
                    tflag_reg <= 1'b0;
                    state_reg <= S_F_RD;
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (sc.free_found)
                    begin
                        word_reg <= '0;
                        if (!tflag_reg && !dir_here)
                        begin
                            frame_reg <= faddr_calc;
                            tflag_reg <= 1'b1;
                            state_reg <= S_F_RD;
                        end
                        else
                        begin
                            res_reg.virt_addr  <= va_reg;
                            res_reg.frame_addr <= tflag_reg ? frame_reg : faddr_calc;
                            res_reg.new_table  <= tflag_reg;
                            res_reg.table_addr <= tflag_reg ? faddr_calc : 32'd0;
                            res_reg.status     <= ST_OK;
                            res_reg.last       <= (page_reg + 1'b1) == cnt_reg;
                            page_reg           <= page_reg + 1'b1;
                            ret_reg   <= ((page_reg + 1'b1) == cnt_reg) ? S_IDLE : S_PAGE;
                            state_reg <= S_POST;
                        end
                    end
                    else if (last_word)
                    begin
                        res_reg   <= error_result(tflag_reg ? ST_NO_TABLE : ST_NO_FRAME);
                        ret_reg   <= S_IDLE;
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_F_RD;
                    end
                end
                S_POST:
                begin
                    if (slot_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

[tb/sv/bitmap_page_allocator_mapper_core_tb.sv]
// Self-checking testbench of the bitmap page allocator and two-level page mapper.
`timescale 1ns / 1ps

module bitmap_page_allocator_mapper_core_tb;
    import bpam_pkg::*;

    localparam int POOL    = DEF_POOL_PAGES;
    localparam int RUN_MAX = DEF_MAX_RUN;
    localparam int DIRS    = DEF_DIR_ENTRIES;

    // A pending request, optionally held back until every result has come home.
    typedef struct {
        in_t req;
        bit  drain;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    bitmap_page_allocator_mapper_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the allocator: registers, bitmaps and directory flags.
    logic [31:0]      sh_virt_base  = RST_VIRT_BASE;
    logic [31:0]      sh_phys_start = RST_PHYS_START;
    logic [KP_W-1:0]  sh_kpages     = RST_KPAGES;
    logic [DIR_W-1:0] sh_dir_first  = RST_DIR_FIRST;
    logic [DIR_W-1:0] sh_dir_last   = RST_DIR_LAST;
    bit virt_map[POOL];
    bit frame_map[POOL];
    bit dir_map[DIRS];

    pending_t pend_q[$];
    out_t     mapping_q[$];
    int       mismatches = 0;

    // The long receiver hold-off is counted here; the stimulus only kicks it.
    int hold_kicks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Usable bitmap length: saturated to the pool size, whole bytes only.
    function automatic int bitmap_len();
        int n;
        n = sh_kpages;
        if (n > POOL)
            n = POOL;
        return n & ~7;
    endfunction

    // Lowest first-fit run of cnt clear bits in the virtual or the frame map.
    function automatic bit first_fit(bit frames, int cnt, output int start);
        int run;
        int len;
        bit used;
        run = 0;
        len = bitmap_len();
        start = 0;
        for (int i = 0; i < len; i++)
        begin
            used = frames ? frame_map[i] : virt_map[i];
            if (used)
                run = 0;
            else
            begin
                run++;
                if (run == cnt)
                begin
                    start = i + 1 - cnt;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit grab_frame(output logic [31:0] addr);
        int idx;
        addr = '0;
        if (!first_fit(1'b1, 1, idx))
            return 1'b0;
        frame_map[idx] = 1'b1;
        addr = sh_phys_start + (32'(idx) << PAGE_SHIFT);
        return 1'b1;
    endfunction

    function automatic bit dir_known(int d);
        if (dir_map[d])
            return 1'b1;
        return sh_dir_first <= sh_dir_last && d >= sh_dir_first && d <= sh_dir_last;
    endfunction

    function automatic out_t fault(status_t st);
        out_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // Works out every mapping that one accepted request produces.
    task automatic map_request(in_t req);
        int cnt;
        int start;
        int d;
        out_t r;
        logic [31:0] fa;
        logic [31:0] ta;
        cnt = req.page_count;
        if (cnt == 0 || cnt > RUN_MAX || cnt >= COUNT_LIMIT)
        begin
            mapping_q.push_back(fault(ST_BAD_COUNT));
            return;
        end
        if (req.pool_select)
        begin
            mapping_q.push_back(fault(ST_USER_POOL));
            return;
        end
        if (!first_fit(1'b0, cnt, start))
        begin
            mapping_q.push_back(fault(ST_NO_RUN));
            return;
        end
        for (int i = 0; i < cnt; i++)
            virt_map[start + i] = 1'b1;
        for (int i = 0; i < cnt; i++)
        begin
            r = '0;
            r.virt_addr = sh_virt_base + (32'(start + i) << PAGE_SHIFT);
            d = r.virt_addr[31:22];
            if (!grab_frame(fa))
            begin
                mapping_q.push_back(fault(ST_NO_FRAME));
                return;
            end
            ta = '0;
            if (!dir_known(d))
            begin
                if (!grab_frame(ta))
                begin
                    mapping_q.push_back(fault(ST_NO_TABLE));
                    return;
                end
                dir_map[d] = 1'b1;
                r.new_table = 1'b1;
            end
            r.frame_addr = fa;
            r.table_addr = ta;
            r.status = ST_OK;
            r.last = (i + 1 == cnt);
            mapping_q.push_back(r);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Request driver. The valid stays up until the request is taken, and a new
    // decision is made only once the previous request has gone.
    int  gap_left = 0;
    int  drv_tick = 0;
    bit  drv_calm = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            drv_tick <= drv_tick + 1;
            if (drv_tick % 300 == 0)
                drv_calm <= ($urandom_range(0, 2) == 0);
            if (in_valid && !in_stall)
                map_request(in_data);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0 &&
                         (!pend_q[0].drain || (mapping_q.size() == 0 && !in_valid)))
                begin
                    in_valid <= 1'b1;
                    in_data <= pend_q.pop_front().req;
                    gap_left <= drv_calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Hold-off counter for the long receiver stall.
    always @(posedge clk)
    begin
        if (hold_kicks != hold_seen)
        begin
            hold_seen <= hold_kicks;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: each mapping taken is checked against the oldest one due.
    int  stall_left = 0;
    int  mon_tick = 0;
    bit  mon_calm = 1'b0;

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            mon_tick <= mon_tick + 1;
            if (mon_tick % 300 == 0)
                mon_calm <= ($urandom_range(0, 2) == 0);
            if (out_valid && !out_stall)
            begin
                if (mapping_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding", $realtime);
                    mismatches++;
                end
                else
                begin
                    want = mapping_q.pop_front();
                    if (out_data.virt_addr != want.virt_addr)
                        report("virt_addr", out_data.virt_addr, want.virt_addr);
                    if (out_data.frame_addr != want.frame_addr)
                        report("frame_addr", out_data.frame_addr, want.frame_addr);
                    if (out_data.new_table != want.new_table)
                        report("new_table", 32'(out_data.new_table), 32'(want.new_table));
                    if (out_data.table_addr != want.table_addr)
                        report("table_addr", out_data.table_addr, want.table_addr);
                    if (out_data.status != want.status)
                        report("status", 32'(out_data.status), 32'(want.status));
                    if (out_data.last != want.last)
                        report("last", 32'(out_data.last), 32'(want.last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (hold_left > 0);
                if (!mon_calm && $urandom_range(0, 7) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    task automatic push_req(bit pool, int cnt, bit drain = 1'b0);
        pending_t p;
        p.req.pool_select = pool;
        p.req.page_count = 12'(cnt);
        p.drain = drain;
        pend_q.push_back(p);
    endtask

    // Blocks until every request has gone and every mapping has come back,
    // then lets the block settle before any register is touched.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || in_valid || mapping_q.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_VIRT_BASE:  sh_virt_base = val;
            CFG_PHYS_START: sh_phys_start = val;
            CFG_KPAGES:     sh_kpages = val[KP_W-1:0];
            CFG_DIR_FIRST:  sh_dir_first = val[DIR_W-1:0];
            CFG_DIR_LAST:   sh_dir_last = val[DIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] vb, logic [31:0] ps, logic [31:0] kp,
                             logic [31:0] df, logic [31:0] dl);
        write_reg(CFG_VIRT_BASE, vb);
        write_reg(CFG_PHYS_START, ps);
        write_reg(CFG_KPAGES, kp);
        write_reg(CFG_DIR_FIRST, df);
        write_reg(CFG_DIR_LAST, dl);
    endtask

    // Random request mix: mostly small kernel runs, some long ones, plus noise.
    task automatic push_random(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                push_req(1'b0, $urandom_range(1, 8), $urandom_range(0, 14) == 0);
            else if (r < 70)
                push_req(1'b0, $urandom_range(9, RUN_MAX));
            else if (r < 85)
                push_req($urandom_range(0, 1), $urandom_range(0, 4095));
            else
                push_req(1'b1, $urandom_range(1, RUN_MAX));
        end
    endtask

    initial
    begin
        logic [31:0] kp;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Tiny eight-page pool with no preset directory entries, so that the
        // frame supply runs dry: first the table frame, then the page frame.
        write_all(32'h0000_0000, 32'h1000_0000, 8, 1, 0);
        push_req(1'b0, 2);
        wait_idle();
        write_reg(CFG_VIRT_BASE, 32'h0040_0000);
        push_req(1'b0, 1);
        wait_idle();
        write_reg(CFG_VIRT_BASE, 32'h0080_0000);
        push_req(1'b0, 1);
        wait_idle();
        write_reg(CFG_VIRT_BASE, 32'h00C0_0000);
        push_req(1'b0, 1);
        push_req(1'b0, 1);
        push_req(1'b0, 4);
        // Count extremes and the user pool, with and without a bad count.
        push_req(1'b0, 0);
        push_req(1'b0, RUN_MAX + 1);
        push_req(1'b0, COUNT_LIMIT);
        push_req(1'b0, 4095);
        push_req(1'b1, 5);
        push_req(1'b1, 4095);
        wait_idle();

        // Loader defaults: the largest run, a single page and the run one short of the largest.
        write_all(RST_VIRT_BASE, RST_PHYS_START, RST_KPAGES, RST_DIR_FIRST,
                  RST_DIR_LAST);
        push_req(1'b0, RUN_MAX);
        push_req(1'b0, 1);
        push_req(1'b0, RUN_MAX - 1);

        // Receiver holds off for a long stretch while requests keep coming,
        // then the sender waits for everything to come back.
        hold_kicks = hold_kicks + 1;
        for (int k = 0; k < 6; k++)
            push_req(1'b0, 8);
        push_req(1'b0, 3, 1'b1);
        wait_idle();

        // Random phases; the first two take the register extremes.
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
                write_all(32'hFFFF_FFFF, 32'hFFFF_F000, 32'h7FFF, 0, 1023);
            else if (ph == 1)
                write_all(32'h0000_0000, 32'h0000_0000, 0, 1023, 0);
            else
            begin
                kp = ($urandom_range(0, 3) == 0) ? 16384 : $urandom_range(8, 2048);
                write_all($urandom(), $urandom(), kp,
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            push_random(ph == 1 ? 10 : 20);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
src/bpam_pkg.sv
src/bpam_word_scan.sv
src/bitmap_page_allocator_mapper_core.sv
tb/sv/bitmap_page_allocator_mapper_core_tb.sv
